@@ src/alpha_content_bounding_box_defines.svh @@
// ----------------------------------------------------------------------------
// Alpha content bounding box: assertion macros
// Shared macros for the concurrent checks of the bounding box block.
// ----------------------------------------------------------------------------
`ifndef ALPHA_CONTENT_BOUNDING_BOX_DEFINES_SVH
`define ALPHA_CONTENT_BOUNDING_BOX_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACBB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("acbb check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ACBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("acbb check failed in the next cycle");

`endif

@@ src/acbb_pkg.sv @@
// ----------------------------------------------------------------------------
// Alpha content bounding box package
// Widths, register indexes, reset values and helpers of the block.
// ----------------------------------------------------------------------------
package acbb_pkg;

    localparam int DEFAULT_MAX_DIM = 4096;

    localparam int DIM_W    = 13;
    localparam int ALPHA_W  = 8;
    localparam int BYTE_W   = 8;
    localparam int COORD_W  = 14;
    localparam int CALC_W   = 18;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_THRESHOLD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_PADDING       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_HALF_SIZE = 3'd4;

    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH        = 13'd256;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT       = 13'd256;
    localparam logic [BYTE_W-1:0] RST_ALPHA_THRESHOLD    = 8'd10;
    localparam logic [BYTE_W-1:0] RST_EDGE_PADDING       = 8'd4;
    localparam logic [BYTE_W-1:0] RST_FALLBACK_HALF_SIZE = 8'd50;

    typedef logic signed [CALC_W-1:0] t_calc;
    typedef logic signed [COORD_W-1:0] t_coord;

    // Clamps a programmed frame size to the supported range.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned max_dim);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (32'(v) > max_dim) begin
            res = DIM_W'(max_dim);
        end
        return res;
    endfunction

endpackage

@@ src/alpha_content_bounding_box.sv @@
// ----------------------------------------------------------------------------
// Alpha content bounding box
// Scans a raster stream of pixel alphas and reports the padded box of
// visible content, or a centered fallback box, once per frame.
// ----------------------------------------------------------------------------
// One pixel is taken every clock cycle while o_stall is low; the only work per
// pixel is a compare-and-update of the running box, done combinationally ahead
// of the result register. The result of a frame appears in the cycle after
// its last pixel is taken. Input stall is high only while the next pixel would
// end a frame and the previous result is still held by a stalled output;
// every other pixel is taken regardless of the output side.
`include "alpha_content_bounding_box_defines.svh"

module alpha_content_bounding_box
    import acbb_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [ALPHA_W-1:0]    i_pixel_alpha,

    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [COORD_W-1:0] o_box_left,
    output logic signed [COORD_W-1:0] o_box_top,
    output logic signed [COORD_W-1:0] o_box_right,
    output logic signed [COORD_W-1:0] o_box_bottom,
    output logic                  o_content_found
);

    localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic [DIM_W-1:0]  r_frame_width;
    logic [DIM_W-1:0]  r_frame_height;
    logic [BYTE_W-1:0] r_alpha_threshold;
    logic [BYTE_W-1:0] r_edge_padding;
    logic [BYTE_W-1:0] r_fallback_half_size;

    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic [CNT_W-1:0] r_least_col;
    logic [CNT_W-1:0] r_greatest_col;
    logic [CNT_W-1:0] r_least_row;
    logic [CNT_W-1:0] r_greatest_row;
    logic             r_seen;

    logic [CNT_W-1:0] n_least_col;
    logic [CNT_W-1:0] n_greatest_col;
    logic [CNT_W-1:0] n_least_row;
    logic [CNT_W-1:0] n_greatest_row;
    logic             n_seen;

    logic             r_out_valid;
    t_coord           r_box_left;
    t_coord           r_box_top;
    t_coord           r_box_right;
    t_coord           r_box_bottom;
    logic             r_content_found;

    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic             row_end;
    logic             frame_end;
    logic             hit;
    logic             in_acc;
    logic             out_free;

    t_calc pad;
    t_calc half;
    t_calc w_last;
    t_calc h_last;
    t_calc left_d;
    t_calc top_d;
    t_calc right_d;
    t_calc bottom_d;
    t_calc n_left;
    t_calc n_top;
    t_calc n_right;
    t_calc n_bottom;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width        <= RST_FRAME_WIDTH;
            r_frame_height       <= RST_FRAME_HEIGHT;
            r_alpha_threshold    <= RST_ALPHA_THRESHOLD;
            r_edge_padding       <= RST_EDGE_PADDING;
            r_fallback_half_size <= RST_FALLBACK_HALF_SIZE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:        r_frame_width        <= i_cfg_data;
                REG_FRAME_HEIGHT:       r_frame_height       <= i_cfg_data;
                REG_ALPHA_THRESHOLD:    r_alpha_threshold    <= i_cfg_data[BYTE_W-1:0];
                REG_EDGE_PADDING:       r_edge_padding       <= i_cfg_data[BYTE_W-1:0];
                REG_FALLBACK_HALF_SIZE: r_fallback_half_size <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff     = eff_dim(r_frame_width, MAX_DIM);
        h_eff     = eff_dim(r_frame_height, MAX_DIM);
        row_end   = 32'(r_col) >= (32'(w_eff) - 32'd1);
        frame_end = row_end && (32'(r_row) >= (32'(h_eff) - 32'd1));
        hit       = i_pixel_alpha > r_alpha_threshold;
        out_free  = !r_out_valid || !i_stall;
        o_stall   = frame_end && !out_free;
        in_acc    = i_valid && !o_stall;
    end

    always_comb begin
        n_least_col    = r_least_col;
        n_greatest_col = r_greatest_col;
        n_least_row    = r_least_row;
        n_greatest_row = r_greatest_row;
        n_seen         = r_seen || hit;
        if (hit) begin
            if (!r_seen || r_col < r_least_col) begin
                n_least_col = r_col;
            end
            if (!r_seen || r_col > r_greatest_col) begin
                n_greatest_col = r_col;
            end
            if (!r_seen || r_row < r_least_row) begin
                n_least_row = r_row;
            end
            if (!r_seen || r_row > r_greatest_row) begin
                n_greatest_row = r_row;
            end
        end
    end

    always_comb begin
        pad      = $signed(CALC_W'(r_edge_padding));
        half     = $signed(CALC_W'(r_fallback_half_size));
        w_last   = $signed(CALC_W'(w_eff)) - t_calc'(1);
        h_last   = $signed(CALC_W'(h_eff)) - t_calc'(1);
        left_d   = $signed(CALC_W'(n_least_col)) - pad;
        top_d    = $signed(CALC_W'(n_least_row)) - pad;
        right_d  = $signed(CALC_W'(n_greatest_col)) + pad;
        bottom_d = $signed(CALC_W'(n_greatest_row)) + pad;
        if (n_seen) begin
            n_left   = (left_d < 0) ? '0 : left_d;
            n_top    = (top_d < 0) ? '0 : top_d;
            n_right  = ((right_d > w_last) ? w_last : right_d) + t_calc'(1);
            n_bottom = ((bottom_d > h_last) ? h_last : bottom_d) + t_calc'(1);
        end else begin
            n_left   = $signed(CALC_W'(w_eff >> 1)) - half;
            n_top    = $signed(CALC_W'(h_eff >> 1)) - half;
            n_right  = $signed(CALC_W'(w_eff >> 1)) + half;
            n_bottom = $signed(CALC_W'(h_eff >> 1)) + half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_seen <= 1'b0;
        end else if (in_acc) begin
            if (frame_end) begin
                r_col  <= '0;
                r_row  <= '0;
                r_seen <= 1'b0;
            end else begin
                r_seen <= n_seen;
                if (row_end) begin
                    r_col <= '0;
                    r_row <= r_row + CNT_W'(1);
                end else begin
                    r_col <= r_col + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_least_col    <= n_least_col;
            r_greatest_col <= n_greatest_col;
            r_least_row    <= n_least_row;
            r_greatest_row <= n_greatest_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= in_acc && frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && frame_end) begin
            r_box_left      <= n_left[COORD_W-1:0];
            r_box_top       <= n_top[COORD_W-1:0];
            r_box_right     <= n_right[COORD_W-1:0];
            r_box_bottom    <= n_bottom[COORD_W-1:0];
            r_content_found <= n_seen;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_box_left      = r_box_left;
    assign o_box_top       = r_box_top;
    assign o_box_right     = r_box_right;
    assign o_box_bottom    = r_box_bottom;
    assign o_content_found = r_content_found;

    `ACBB_ASSERT_SAME(a_stall_needs_held_result, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `ACBB_ASSERT_NEXT(a_no_result_mid_frame, i_clk, i_rst_n,
                      in_acc && !frame_end && out_free, !o_valid)
    `ACBB_ASSERT_SAME(a_found_box_not_negative, i_clk, i_rst_n, o_valid && o_content_found,
                      !o_box_left[COORD_W-1] && !o_box_top[COORD_W-1])

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Alpha content bounding box testbench
// Streams pixel alphas through the block under random idling on both sides
// and checks every frame report against a scan model kept inside the bench.
// A short directed table comes first, then random frames of mostly small
// sizes with reconfiguration between them and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import acbb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM       = DEFAULT_MAX_DIM;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int RANDOM_PIXELS  = 330;

    typedef struct packed {
        t_coord box_left;
        t_coord box_top;
        t_coord box_right;
        t_coord box_bottom;
        logic   content_found;
    } box_t;

    typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_e;
    typedef enum logic [1:0] {MIX_SPARSE, MIX_UNIFORM, MIX_EDGE} alpha_mix_e;

    typedef struct {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
        bit                    typed;
        box_t                  want;
    } stim_row_t;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [ALPHA_W-1:0]    i_pixel_alpha = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_coord                o_box_left;
    t_coord                o_box_top;
    t_coord                o_box_right;
    t_coord                o_box_bottom;
    logic                  o_content_found;

    alpha_content_bounding_box #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_alpha  (i_pixel_alpha),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_box_left     (o_box_left),
        .o_box_top      (o_box_top),
        .o_box_right    (o_box_right),
        .o_box_bottom   (o_box_bottom),
        .o_content_found(o_content_found)
    );

    logic [DIM_W-1:0]  cfg_width     = RST_FRAME_WIDTH;
    logic [DIM_W-1:0]  cfg_height    = RST_FRAME_HEIGHT;
    logic [BYTE_W-1:0] cfg_threshold = RST_ALPHA_THRESHOLD;
    logic [BYTE_W-1:0] cfg_padding   = RST_EDGE_PADDING;
    logic [BYTE_W-1:0] cfg_half_size = RST_FALLBACK_HALF_SIZE;

    int scan_col = 0;
    int scan_row = 0;
    int min_col  = int'(RST_FRAME_WIDTH);
    int max_col  = 0;
    int min_row  = int'(RST_FRAME_HEIGHT);
    int max_row  = 0;
    bit any_content = 1'b0;

    box_t      pending_boxes[$];
    stim_row_t directed_rows[$];

    int failures            = 0;
    int pixels_sent         = 0;
    int frames_predicted    = 0;
    int frames_reported     = 0;
    int frames_with_content = 0;
    int register_writes     = 0;
    int sender_idle_pct     = 0;
    int receiver_idle_pct   = 0;
    int holdoff_request     = 0;
    int holdoff_left        = 0;
    int idle_cycles         = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic void advance_scan(input logic [ALPHA_W-1:0] alpha, output bit done,
                                         output box_t res);
        int w, h, x, y, lft, tp, rgt, btm, pad, hs;
        bit row_end;
        w = clamp_dim(cfg_width);
        h = clamp_dim(cfg_height);
        x = scan_col;
        y = scan_row;
        row_end = (x >= w - 1);
        done = row_end && (y >= h - 1);
        res = '0;
        if (alpha > cfg_threshold) begin
            if (!any_content || x < min_col) min_col = x;
            if (!any_content || x > max_col) max_col = x;
            if (!any_content || y < min_row) min_row = y;
            if (!any_content || y > max_row) max_row = y;
            any_content = 1'b1;
        end
        if (!done) begin
            if (row_end) begin
                scan_col = 0;
                scan_row = y + 1;
            end else begin
                scan_col = x + 1;
            end
        end else begin
            pad = int'(cfg_padding);
            if (any_content) begin
                lft = min_col - pad;
                if (lft < 0) lft = 0;
                tp = min_row - pad;
                if (tp < 0) tp = 0;
                rgt = max_col + pad;
                if (rgt > w - 1) rgt = w - 1;
                btm = max_row + pad;
                if (btm > h - 1) btm = h - 1;
                rgt = rgt + 1;
                btm = btm + 1;
            end else begin
                hs = int'(cfg_half_size);
                lft = w / 2 - hs;
                tp = h / 2 - hs;
                rgt = w / 2 + hs;
                btm = h / 2 + hs;
            end
            res.box_left      = lft[COORD_W-1:0];
            res.box_top       = tp[COORD_W-1:0];
            res.box_right     = rgt[COORD_W-1:0];
            res.box_bottom    = btm[COORD_W-1:0];
            res.content_found = any_content;
            scan_col = 0;
            scan_row = 0;
            min_col = w;
            max_col = 0;
            min_row = h;
            max_row = 0;
            any_content = 1'b0;
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            REG_FRAME_WIDTH:        cfg_width = data;
            REG_FRAME_HEIGHT:       cfg_height = data;
            REG_ALPHA_THRESHOLD:    cfg_threshold = data[BYTE_W-1:0];
            REG_EDGE_PADDING:       cfg_padding = data[BYTE_W-1:0];
            REG_FALLBACK_HALF_SIZE: cfg_half_size = data[BYTE_W-1:0];
            default: ;
        endcase
        register_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic [ALPHA_W-1:0] alpha, input bit typed,
                              input box_t want);
        bit done;
        box_t predicted;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_alpha <= alpha;
        do @(posedge i_clk); while (o_stall);
        pixels_sent++;
        advance_scan(alpha, done, predicted);
        if (done) begin
            frames_predicted++;
            pending_boxes.push_back(typed ? want : predicted);
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending_boxes.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic signed [15:0] want,
                               input logic signed [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    function automatic void add_write(input logic [CFG_IDX_W-1:0] index,
                                      input logic [CFG_DATA_W-1:0] value);
        stim_row_t row;
        row.kind = ROW_WRITE;
        row.index = index;
        row.value = value;
        row.typed = 1'b0;
        row.want = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_pixel(input logic [ALPHA_W-1:0] alpha);
        stim_row_t row;
        row.kind = ROW_PIXEL;
        row.index = '0;
        row.value = CFG_DATA_W'(alpha);
        row.typed = 1'b0;
        row.want = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_pixel_box(input logic [ALPHA_W-1:0] alpha, input t_coord l,
                                          input t_coord t, input t_coord r, input t_coord b,
                                          input logic f);
        stim_row_t row;
        row.kind = ROW_PIXEL;
        row.index = '0;
        row.value = CFG_DATA_W'(alpha);
        row.typed = 1'b1;
        row.want.box_left = l;
        row.want.box_top = t;
        row.want.box_right = r;
        row.want.box_bottom = b;
        row.want.content_found = f;
        directed_rows.push_back(row);
    endfunction

    function automatic void build_directed_table();
        // 2x2 frames with the reset padding and half size, at the reset threshold and then at 255.
        add_write(REG_FRAME_WIDTH, 13'd2);
        add_write(REG_FRAME_HEIGHT, 13'd2);
        add_pixel(8'd10);
        add_pixel(8'd10);
        add_pixel(8'd10);
        add_pixel_box(8'd10, -14'sd49, -14'sd49, 14'sd51, 14'sd51, 1'b0);
        add_pixel(8'd0);
        add_pixel(8'd11);
        add_pixel(8'd0);
        add_pixel_box(8'd0, 14'sd0, 14'sd0, 14'sd2, 14'sd2, 1'b1);
        add_write(REG_ALPHA_THRESHOLD, 13'd255);
        add_pixel(8'd255);
        add_pixel(8'd255);
        add_pixel(8'd255);
        add_pixel_box(8'd255, -14'sd49, -14'sd49, 14'sd51, 14'sd51, 1'b0);
        // Zero sizes count as one pixel.
        add_write(REG_ALPHA_THRESHOLD, 13'd0);
        add_write(REG_EDGE_PADDING, 13'd0);
        add_write(REG_FALLBACK_HALF_SIZE, 13'd0);
        add_write(REG_FRAME_WIDTH, 13'd0);
        add_write(REG_FRAME_HEIGHT, 13'd0);
        add_pixel_box(8'd1, 14'sd0, 14'sd0, 14'sd1, 14'sd1, 1'b1);
        add_pixel_box(8'd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 1'b0);
        add_write(REG_FALLBACK_HALF_SIZE, 13'd255);
        add_pixel_box(8'd0, -14'sd255, -14'sd255, 14'sd255, 14'sd255, 1'b0);
        add_write(REG_FRAME_WIDTH, 13'd3);
        add_write(REG_FRAME_HEIGHT, 13'd1);
        add_write(REG_EDGE_PADDING, 13'd1);
        add_pixel(8'd0);
        add_pixel(8'd0);
        add_pixel_box(8'd5, 14'sd1, 14'sd0, 14'sd3, 14'sd1, 1'b1);
        // The row shrinks under the scan, leaving the left edge outside the frame.
        add_write(REG_FRAME_WIDTH, 13'd4);
        add_write(REG_FRAME_HEIGHT, 13'd2);
        add_pixel(8'd0);
        add_pixel(8'd0);
        add_pixel(8'd0);
        add_write(REG_FRAME_WIDTH, 13'd2);
        add_pixel(8'd9);
        add_pixel(8'd0);
        add_pixel(8'd0);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 75) return CFG_DATA_W'($urandom_range(1, 6));
        if (r < 95) return CFG_DATA_W'($urandom_range(7, 16));
        return CFG_DATA_W'($urandom_range(17, 40));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return '0;
        if (r < 24) return CFG_DATA_W'(255);
        if (r < 60) return CFG_DATA_W'($urandom_range(0, 12));
        return CFG_DATA_W'($urandom_range(0, 8191));
    endfunction

    task automatic run_random(input int target);
        int sent, area, n;
        alpha_mix_e mix;
        logic [ALPHA_W-1:0] a;
        sent = 0;
        while (sent < target) begin
            settle();
            if ($urandom_range(0, 9) < 6) write_reg(REG_FRAME_WIDTH, pick_dim());
            if ($urandom_range(0, 9) < 6) write_reg(REG_FRAME_HEIGHT, pick_dim());
            if ($urandom_range(0, 9) < 6) write_reg(REG_ALPHA_THRESHOLD, pick_byte());
            if ($urandom_range(0, 9) < 6) write_reg(REG_EDGE_PADDING, pick_byte());
            if ($urandom_range(0, 9) < 6) write_reg(REG_FALLBACK_HALF_SIZE, pick_byte());
            area = clamp_dim(cfg_width) * clamp_dim(cfg_height);
            n = area * $urandom_range(1, 3);
            if ($urandom_range(0, 2) == 0) n += $urandom_range(0, area - 1);
            if (n > 160) n = $urandom_range(60, 160);
            mix = alpha_mix_e'($urandom_range(0, 2));
            repeat (n) begin
                case (mix)
                    MIX_SPARSE:  a = ($urandom_range(0, 15) == 0) ?
                                     ALPHA_W'($urandom_range(0, 255)) : '0;
                    MIX_UNIFORM: a = ALPHA_W'($urandom_range(0, 255));
                    default:     a = cfg_threshold + ALPHA_W'($urandom_range(0, 2)) - 8'd1;
                endcase
                send_pixel(a, 1'b0, '0);
            end
            sent += n;
        end
    endtask

    initial begin
        box_t exp_box;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_boxes.size() == 0) begin
                    $error("frame report with no frame pending: %0d %0d %0d %0d %0b",
                           o_box_left, o_box_top, o_box_right, o_box_bottom,
                           o_content_found);
                    failures++;
                end else begin
                    exp_box = pending_boxes.pop_front();
                    check_field("box_left", 16'(exp_box.box_left), 16'(o_box_left));
                    check_field("box_top", 16'(exp_box.box_top), 16'(o_box_top));
                    check_field("box_right", 16'(exp_box.box_right), 16'(o_box_right));
                    check_field("box_bottom", 16'(exp_box.box_bottom), 16'(o_box_bottom));
                    check_field("content_found", 16'(exp_box.content_found),
                                16'(o_content_found));
                    frames_reported++;
                    if (exp_box.content_found) frames_with_content++;
                end
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                i_stall <= 1'b1;
            end else if (holdoff_request > 0) begin
                holdoff_left = holdoff_request - 1;
                holdoff_request = 0;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
            end
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("alpha_content_bounding_box: mismatch");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 28;
        receiver_idle_pct = 62;
        build_directed_table();
        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_WRITE) begin
                settle();
                write_reg(directed_rows[k].index, directed_rows[k].value);
            end else begin
                send_pixel(directed_rows[k].value[ALPHA_W-1:0], directed_rows[k].typed,
                           directed_rows[k].want);
            end
        end

        run_random(RANDOM_PIXELS);

        sender_idle_pct = 62;
        receiver_idle_pct = 28;
        run_random(RANDOM_PIXELS);

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        settle();
        write_reg(REG_FRAME_WIDTH, 13'd2);
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        holdoff_request = HOLDOFF_CYCLES;
        repeat (60) send_pixel(ALPHA_W'($urandom_range(0, 255)), 1'b0, '0);
        run_random(RANDOM_PIXELS);

        i_valid <= 1'b0;
        while (pending_boxes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Scanned %0d pixels into %0d frame reports (%0d with content, %0d fallback).",
                 pixels_sent, frames_reported, frames_with_content,
                 frames_reported - frames_with_content);
        $display("Used %0d register writes, zero sizes and sizes up to 40, %s",
                 register_writes, "mid-frame resizes and a long hold-off.");
        if (failures == 0 && pending_boxes.size() == 0) begin
            $display("alpha_content_bounding_box: match");
        end else begin
            $display("alpha_content_bounding_box: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/acbb_pkg.sv
src/alpha_content_bounding_box.sv
dv/tb.sv
